// File: rtl/core/wlan_frame_descrambler_defines.svh
// ---------------------------------------------------------------------------
// wlan frame descrambler assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef WLAN_FRAME_DESCRAMBLER_DEFINES_SVH
`define WLAN_FRAME_DESCRAMBLER_DEFINES_SVH

// same-cycle implication
`define WFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wfd_pkg.sv
// ---------------------------------------------------------------------------
// wfd_pkg
// widths and constants of the 802.11 frame descrambler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wfd_pkg;

  localparam int PSDU_W     = 12;
  localparam int IDX_W      = 13;
  localparam int CNT_W      = 16;
  localparam int LFSR_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [PSDU_W-1:0] PSDU_RESET = 12'd28;
  localparam logic [IDX_W-1:0]  MSG_FIRST  = 13'd26;
  localparam logic [IDX_W:0]    MSG_TAIL   = 14'd3;
  localparam logic [CNT_W-1:0]  SEED_BITS  = 16'd7;
  localparam logic [CNT_W-1:0]  FRAME_BITS_MAX = 16'd32776;

  // register index, taken from paddr word bit
  localparam logic REG_PAYLOAD_LEN = 1'b0;

  typedef logic [LFSR_W-1:0] lfsr_t;
  typedef logic [CNT_W-1:0]  bit_count_t;

endpackage

// File: rtl/core/wfd_if.sv
// ---------------------------------------------------------------------------
// wfd channel interfaces
// valid/ready channels for scrambled bits in and descrambled words out
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wfd_in_if import wfd_pkg::*; ();
  logic valid;
  logic ready;
  logic data_bit;
  logic frame_start;

  modport source (output valid, output data_bit, output frame_start, input ready);
  modport sink   (input valid, input data_bit, input frame_start, output ready);
endinterface

interface wfd_out_if import wfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic [IDX_W-1:0]  byte_index;
  logic              in_message;
  logic              last;

  modport source (output valid, output byte_value, output byte_index,
                  output in_message, output last, input ready);
  modport sink   (input valid, input byte_value, input byte_index,
                  input in_message, input last, output ready);
endinterface

// File: rtl/core/wlan_frame_descrambler.sv
// ---------------------------------------------------------------------------
// wlan_frame_descrambler
// 802.11 x^7+x^4+1 descrambler, one bit per word in, one byte per word out
// ---------------------------------------------------------------------------
// Takes one scrambled bit per cycle while in_ch.ready is high, LSB-first
// within each byte after the seed, and registers each descrambled byte as the
// bit that completes it is taken, with its index, a message-window flag (bytes
// 26 to payload length - 3) and a last flag on byte payload length + 1. The
// first seven bits of a frame seed the LFSR and form bits 6..0 of byte 0, in
// that order; bits past (payload length + 2) * 8 are taken and dropped until
// frame_start. The LFSR, bit counter and byte accumulator update together on
// each bit taken inside the frame. While a finished byte waits in the output
// register, bits keep entering until the one that would complete the next
// byte, which stalls until the waiting byte is taken. The payload length
// register sits at byte address 0 and should be written while no frame is in flight.
`timescale 1ns / 1ps

`include "wlan_frame_descrambler_defines.svh"

module wlan_frame_descrambler
  import wfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  wfd_in_if.sink                in_ch,
  wfd_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [PSDU_W-1:0] psdu_r;
  lfsr_t             lfsr_r, lfsr_nxt;
  bit_count_t        bit_count_r;
  logic [BYTE_W-1:0] acc_r, acc_nxt;

  logic              out_valid_r;
  logic [BYTE_W-1:0] byte_value_r;
  logic [IDX_W-1:0]  byte_index_r;
  logic              in_message_r;
  logic              last_r;

  logic              in_fire;
  bit_count_t        pos;
  bit_count_t        total_bits;
  logic              active;
  logic              emit;
  lfsr_t             lfsr_base;
  logic [BYTE_W-1:0] acc_base;
  logic              fb;
  logic [IDX_W-1:0]  idx;
  logic              in_msg;
  logic              is_last;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PAYLOAD_LEN) ?
                  {{(CFG_DATA_W-PSDU_W){1'b0}}, psdu_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psdu_r <= PSDU_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_PAYLOAD_LEN) begin
      psdu_r <= pwdata[PSDU_W-1:0];
    end
  end

  // datapath
  // only a bit that can finish a byte, or a frame_start bit in that position, has to wait for the output register
  assign in_ch.ready = !out_valid_r || out_ch.ready || (bit_count_r[2:0] != 3'd7);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    pos        = in_ch.frame_start ? '0 : bit_count_r;
    total_bits = (CNT_W'(psdu_r) + CNT_W'(2)) << 3;
    active     = pos < total_bits;
    emit       = (pos[2:0] == 3'd7);
    lfsr_base  = (pos == '0) ? '0 : lfsr_r;
    acc_base   = (pos == '0) ? '0 : acc_r;
    fb         = lfsr_base[6] ^ lfsr_base[3];
    if (pos < SEED_BITS) begin
      lfsr_nxt = lfsr_base | ({in_ch.data_bit, 6'b0} >> pos[2:0]);
      acc_nxt  = {1'b0, lfsr_nxt};
    end else begin
      lfsr_nxt = {lfsr_base[LFSR_W-2:0], fb};
      acc_nxt  = acc_base | ({7'b0, fb ^ in_ch.data_bit} << pos[2:0]);
    end
    idx     = pos[CNT_W-1:3];
    in_msg  = (idx >= MSG_FIRST) && ((14'(idx) + MSG_TAIL) <= 14'(psdu_r));
    is_last = (idx == (IDX_W'(psdu_r) + IDX_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r      <= '0;
      bit_count_r <= '0;
      acc_r       <= '0;
    end else if (in_fire && active) begin
      lfsr_r      <= lfsr_nxt;
      bit_count_r <= pos + CNT_W'(1);
      acc_r       <= emit ? '0 : acc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && active && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && active && emit) begin
      byte_value_r <= acc_nxt;
      byte_index_r <= idx;
      in_message_r <= in_msg;
      last_r       <= is_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.byte_value = byte_value_r;
  assign out_ch.byte_index = byte_index_r;
  assign out_ch.in_message = in_message_r;
  assign out_ch.last       = last_r;

  // checks
  `WFD_ASSERT_SAME(a_count_bound, 1'b1, bit_count_r <= FRAME_BITS_MAX,
    "bit counter ran past the longest frame")
  `WFD_ASSERT_NEXT(a_start_count, in_fire && in_ch.frame_start, bit_count_r == CNT_W'(1),
    "frame start did not restart the bit counter")
  `WFD_ASSERT_SAME(a_last_not_msg, out_valid_r && last_r, !in_message_r,
    "last byte flagged inside message window")
  `WFD_ASSERT_SAME(a_msg_index, out_valid_r && in_message_r, byte_index_r >= MSG_FIRST,
    "message flag below first message byte")

endmodule

// File: tb/wlan_frame_descrambler_tb.sv
// ---------------------------------------------------------------------------
// wlan_frame_descrambler_tb
// Sends scrambled frame bits over the input channel and checks every byte
// that comes out against a descrambler model kept in the bench. Frames use
// small payload lengths, one size with a message window and one very large
// size cut short, and include aborted frames, bits past the frame end and
// size changes between bytes. Both channels idle and stall at random, and
// the output side holds off once for long enough to back the input up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlan_frame_descrambler_tb;
  import wfd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] PAYLOAD_LEN_ADDR = {REG_PAYLOAD_LEN, 2'b00};
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_BITS  = 32;
  localparam int FILL_ZEROS   = 0;
  localparam int FILL_ONES    = 1;
  localparam int FILL_RANDOM  = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic              in_msg;
    logic              last;
  } byte_word_t;

  class frame_byte_scoreboard;
    logic [PSDU_W-1:0] psdu_bytes;
    lfsr_t             lfsr_state;
    bit_count_t        next_bit;
    logic [BYTE_W-1:0] byte_acc;
    byte_word_t        pending[$];
    int errors;
    int bytes_checked;
    int bits_taken;
    int bits_dropped;

    function new();
      psdu_bytes    = PSDU_RESET;
      lfsr_state    = '0;
      next_bit      = '0;
      byte_acc      = '0;
      errors        = 0;
      bytes_checked = 0;
      bits_taken    = 0;
      bits_dropped  = 0;
    endfunction

    function void set_psdu(logic [PSDU_W-1:0] v);
      psdu_bytes = v;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // descrambler prediction for one accepted bit
    function void note_bit(logic d, logic s);
      int         total;
      int         idx;
      logic       fb;
      byte_word_t w;
      total = (int'(psdu_bytes) + 2) * 8;
      bits_taken++;
      if (s) next_bit = '0;
      if (int'(next_bit) >= total) begin
        bits_dropped++;
        return;
      end
      if (next_bit == '0) begin
        lfsr_state = '0;
        byte_acc   = '0;
      end
      if (next_bit < SEED_BITS) begin
        if (d) lfsr_state[LFSR_W - 1 - int'(next_bit[2:0])] = 1'b1;
        byte_acc = {1'b0, lfsr_state};
      end else begin
        fb = lfsr_state[6] ^ lfsr_state[3];
        byte_acc[next_bit[2:0]] = fb ^ d;
        lfsr_state = {lfsr_state[LFSR_W-2:0], fb};
      end
      if (next_bit[2:0] == 3'd7) begin
        idx      = int'(next_bit >> 3);
        w.value  = byte_acc;
        w.index  = IDX_W'(idx);
        w.in_msg = (idx >= int'(MSG_FIRST)) && (idx + int'(MSG_TAIL) <= int'(psdu_bytes));
        w.last   = (idx == int'(psdu_bytes) + 1);
        pending.push_back(w);
        byte_acc = '0;
      end
      next_bit = next_bit + 1'b1;
    endfunction

    function void check_byte(byte_word_t got);
      byte_word_t want;
      bytes_checked++;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected word: index %0d value %02h msg %0b last %0b",
                       got.index, got.value, got.in_msg, got.last));
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value || got.index !== want.index ||
          got.in_msg !== want.in_msg || got.last !== want.last) begin
        flag($sformatf("expected index %0d value %02h msg %0b last %0b, got index %0d value %02h msg %0b last %0b",
                       want.index, want.value, want.in_msg, want.last,
                       got.index, got.value, got.in_msg, got.last));
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  wfd_in_if  in_if ();
  wfd_out_if out_if ();

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  frame_byte_scoreboard sb = new();

  int   burst_left     = 0;
  int   settings_used  = 0;
  int   random_bits    = 0;
  int   rx_mode        = 0;
  int   rx_left        = 0;
  int   rx_phase       = 0;
  int   hold_left      = 0;
  bit   long_hold_done = 1'b0;
  logic [7:0] rx_pattern = 8'hff;

  wlan_frame_descrambler uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  initial begin
    #15_000_000;
    $display("timeout: %0d bytes still expected", sb.pending.size());
    $display("Test completed with failures");
    $finish;
  end

  // output side stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (!long_hold_done && sb.bytes_checked >= 30) begin
      hold_left      = LONG_HOLD;
      long_hold_done = 1'b1;
    end
    if (rx_left == 0) begin
      rx_mode    = $urandom_range(0, 2);
      rx_pattern = 8'($urandom) | 8'h01;
      rx_left    = $urandom_range(32, 128);
    end
    rx_left--;
    rx_phase = (rx_phase + 1) % 8;
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: begin
          out_if.ready <= 1'b1;
        end
        1: begin
          out_if.ready <= rx_pattern[rx_phase];
        end
        default: begin
          out_if.ready <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_byte(byte_word_t'{out_if.byte_value, out_if.byte_index,
                                 out_if.in_message, out_if.last});
    end
  end

  function automatic int frame_len();
    return (int'(sb.psdu_bytes) + 2) * 8;
  endfunction

  task automatic push_bit(input logic d, input logic s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_if.valid       <= 1'b1;
    in_if.data_bit    <= d;
    in_if.frame_start <= s;
    do @(posedge clk); while (!in_if.ready);
    sb.note_bit(d, s);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_frame(input int nbits, input logic first_start, input int fill);
    logic d;
    for (int i = 0; i < nbits; i++) begin
      d = (fill == FILL_RANDOM) ? 1'($urandom_range(0, 1)) : (fill == FILL_ONES);
      push_bit(d, (i == 0) ? first_start : 1'b0);
    end
  endtask

  // bits with no frame_start, dropped when past the frame end
  task automatic send_noise(input int nbits);
    for (int i = 0; i < nbits; i++) push_bit(1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == PAYLOAD_LEN_ADDR) sb.set_psdu(data[PSDU_W-1:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_read(input logic [CFG_ADDR_W-1:0] addr,
                          output logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_psdu_readback();
    logic [CFG_DATA_W-1:0] rd;
    cfg_read(PAYLOAD_LEN_ADDR, rd);
    if (rd[PSDU_W-1:0] !== sb.psdu_bytes) begin
      sb.flag($sformatf("payload length reads %0d, expected %0d",
                        rd[PSDU_W-1:0], sb.psdu_bytes));
    end
  endtask

  task automatic set_payload_len(input int n);
    logic [CFG_DATA_W-1:0] word;
    wait_idle();
    word = ($urandom & ~32'hfff) | CFG_DATA_W'(n);
    cfg_write(PAYLOAD_LEN_ADDR, word);
    check_psdu_readback();
    settings_used++;
  endtask

  initial begin
    int psdu;
    int nframes;
    int kind;
    int cut;
    in_if.valid       = 1'b0;
    in_if.data_bit    = 1'b0;
    in_if.frame_start = 1'b0;
    out_if.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_psdu_readback();

    // first frame after reset starts without frame_start, cut after two bytes
    send_frame(16, 1'b0, FILL_RANDOM);

    // two-byte frames: all ones, all zeros, aborted, then clean and run past the end
    set_payload_len(0);
    send_frame(frame_len(), 1'b1, FILL_ONES);
    send_frame(frame_len(), 1'b1, FILL_ZEROS);
    send_frame(11, 1'b1, FILL_RANDOM);
    send_frame(frame_len(), 1'b1, FILL_RANDOM);
    send_noise(5);

    // size shrinks between bytes but frame goes on, one message byte
    set_payload_len(40);
    send_frame(80, 1'b1, FILL_RANDOM);
    set_payload_len(29);
    send_frame(frame_len() - 80, 1'b0, FILL_RANDOM);
    send_noise(6);

    // size drops below the bits already taken
    send_frame(40, 1'b1, FILL_RANDOM);
    set_payload_len(2);
    send_noise(8);
    send_frame(frame_len(), 1'b1, FILL_RANDOM);

    // largest size, frame cut short
    set_payload_len(4095);
    send_frame(16, 1'b1, FILL_RANDOM);

    // random short frames
    while (random_bits < RANDOM_BITS) begin
      psdu = $urandom_range(0, 3);
      set_payload_len(psdu);
      nframes = $urandom_range(1, 2);
      repeat (nframes) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          cut = $urandom_range(1, frame_len() - 1);
          send_frame(cut, 1'b1, FILL_RANDOM);
          random_bits += cut;
        end else begin
          send_frame(frame_len(), 1'b1, FILL_RANDOM);
          random_bits += frame_len();
          if (kind == 1) send_noise($urandom_range(1, 10));
        end
      end
    end

    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES * 4) @(negedge clk);
    if (sb.pending.size() != 0) sb.flag($sformatf("%0d bytes never arrived", sb.pending.size()));

    $display("ran %0d bits (%0d dropped outside a frame) and checked %0d bytes",
             sb.bits_taken, sb.bits_dropped, sb.bytes_checked);
    $display("over %0d payload length settings from 0 to 4095, %0d errors",
             settings_used, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
